// ----- hw/rtl/ecdsa_der_pkg.sv -----
package ecdsa_der_pkg;

    localparam int unsigned MAX_INT_LEN = 100;
    localparam logic [7:0]  TAG_INTEGER = 8'h02;
    localparam logic [7:0]  ZERO_BYTE   = 8'h00;
    localparam logic [7:0]  ONE_BYTE    = 8'h01;
    localparam int unsigned DER_EXTRA   = (2 + 1) * 2;
    localparam int unsigned BURST_MAX   = 4;

    localparam logic [6:0] RESET_R_LENGTH        = 7'd32;
    localparam logic [6:0] RESET_S_LENGTH        = 7'd32;
    localparam logic [7:0] RESET_BUFFER_CAPACITY = 8'd70;

    typedef enum logic [1:0] {
        CFG_R_LENGTH        = 2'd0,
        CFG_S_LENGTH        = 2'd1,
        CFG_BUFFER_CAPACITY = 2'd2,
        CFG_UNUSED          = 2'd3
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_LEN_ERR = 2'd1,
        ST_CAP_ERR = 2'd2
    } t_status;

    typedef struct packed {
        logic       s_part;
        logic [6:0] byte_count;
        logic       stripping;
        logic [7:0] emitted;
    } t_seq_state;

    typedef struct packed {
        logic [BURST_MAX-1:0][7:0] bytes;
        logic [2:0]                cnt;
        logic                      data;
        logic                      last;
        t_status                   status;
        logic [7:0]                total;
    } t_burst;

endpackage

// ----- hw/rtl/ecdsa_der_expand.sv -----
module ecdsa_der_expand (
    input  logic [6:0]                i_r_length,
    input  logic [6:0]                i_s_length,
    input  logic [7:0]                i_buffer_capacity,
    input  ecdsa_der_pkg::t_seq_state i_state,
    input  logic [7:0]                i_in_byte,
    output ecdsa_der_pkg::t_seq_state o_state,
    output ecdsa_der_pkg::t_burst     o_burst
);

    logic [6:0]             len;
    logic                   ends;
    logic                   final_byte;
    ecdsa_der_pkg::t_status err;
    logic [8:0]             need;
    logic [6:0]             rem;
    logic                   pad;
    logic [7:0]             len_byte;

    always_comb begin
        len        = i_state.s_part ? i_s_length : i_r_length;
        ends       = ({1'b0, i_state.byte_count} + 8'd1) >= {1'b0, len};
        final_byte = i_state.s_part && ends;
        need       = {2'b0, i_r_length} + {2'b0, i_s_length}
                     + 9'(ecdsa_der_pkg::DER_EXTRA);
        if (i_r_length == 7'd0 || i_r_length > 7'(ecdsa_der_pkg::MAX_INT_LEN) ||
            i_s_length == 7'd0 || i_s_length > 7'(ecdsa_der_pkg::MAX_INT_LEN)) begin
            err = ecdsa_der_pkg::ST_LEN_ERR;
        end else if ({1'b0, i_buffer_capacity} < need) begin
            err = ecdsa_der_pkg::ST_CAP_ERR;
        end else begin
            err = ecdsa_der_pkg::ST_OK;
        end
        rem      = (i_state.byte_count < len) ? (len - i_state.byte_count) : 7'd1;
        pad      = i_in_byte[7];
        len_byte = {1'b0, rem} + {7'b0, pad};
    end

    always_comb begin
        o_burst        = '0;
        o_burst.data   = 1'b1;
        o_burst.status = ecdsa_der_pkg::ST_OK;
        o_state        = i_state;

        if (err != ecdsa_der_pkg::ST_OK) begin
            if (final_byte) begin
                o_burst.cnt    = 3'd1;
                o_burst.data   = 1'b0;
                o_burst.last   = 1'b1;
                o_burst.status = err;
            end
        end else if (i_state.stripping) begin
            if (i_in_byte != 8'd0) begin
                o_burst.bytes[0] = ecdsa_der_pkg::TAG_INTEGER;
                o_burst.bytes[1] = len_byte;
                if (pad) begin
                    o_burst.bytes[2] = ecdsa_der_pkg::ZERO_BYTE;
                    o_burst.bytes[3] = i_in_byte;
                    o_burst.cnt      = 3'd4;
                end else begin
                    o_burst.bytes[2] = i_in_byte;
                    o_burst.cnt      = 3'd3;
                end
                o_state.stripping = 1'b0;
            end else if (ends) begin
                o_burst.bytes[0] = ecdsa_der_pkg::TAG_INTEGER;
                o_burst.bytes[1] = ecdsa_der_pkg::ONE_BYTE;
                o_burst.bytes[2] = ecdsa_der_pkg::ZERO_BYTE;
                o_burst.cnt      = 3'd3;
            end
        end else begin
            o_burst.bytes[0] = i_in_byte;
            o_burst.cnt      = 3'd1;
        end

        if (err == ecdsa_der_pkg::ST_OK) begin
            o_state.emitted = i_state.emitted + {5'b0, o_burst.cnt};
            if (final_byte && o_burst.cnt != 3'd0) begin
                o_burst.last  = 1'b1;
                o_burst.total = o_state.emitted;
            end
        end

        if (ends) begin
            if (i_state.s_part) begin
                o_state.s_part     = 1'b0;
                o_state.byte_count = 7'd0;
                o_state.stripping  = 1'b1;
                o_state.emitted    = 8'd0;
            end else begin
                o_state.s_part     = 1'b1;
                o_state.byte_count = 7'd0;
                o_state.stripping  = 1'b1;
            end
        end else begin
            o_state.byte_count = i_state.byte_count + 7'd1;
        end
    end

endmodule

// ----- hw/rtl/ecdsa_rs_der_integer_encoder_unit.sv -----
// DER INTEGER encoder for the r and s halves of an ECDSA signature. Feed the
// big-endian bytes of r, then of s, one byte per input transfer; the unit emits
// 02 len [00] value for each half with leading zero bytes dropped, or a single
// status-only result on the final byte when the lengths or buffer capacity are
// invalid. One input byte is taken per cycle unless stalled; it expands into up
// to four results held in a small burst register that drains one result per
// cycle while the output is not stalled. Input stalls while more than one result
// is left, as in a header burst (three or four bytes, once per half), or while
// the last one is stalled at the output. Configure only while idle.
module ecdsa_rs_der_integer_encoder_unit (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [1:0] i_cfg_index,
    input  logic [7:0] i_cfg_data,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_in_byte,
    output logic       o_res_valid,
    input  logic       i_res_stall,
    output logic [7:0] o_out_byte,
    output logic       o_out_valid,
    output logic       o_last,
    output logic [1:0] o_status,
    output logic [7:0] o_total_length
);

    logic [6:0]                r_r_length;
    logic [6:0]                r_s_length;
    logic [7:0]                r_buffer_capacity;
    ecdsa_der_pkg::t_seq_state r_state;
    ecdsa_der_pkg::t_seq_state n_state;
    ecdsa_der_pkg::t_burst     r_burst;
    ecdsa_der_pkg::t_burst     n_burst;
    logic [2:0]                r_head;
    logic [2:0]                remaining;
    logic                      in_xfer;
    logic                      res_xfer;
    logic                      at_tail;

    ecdsa_der_expand u_expand (
        .i_r_length        (r_r_length),
        .i_s_length        (r_s_length),
        .i_buffer_capacity (r_buffer_capacity),
        .i_state           (r_state),
        .i_in_byte         (i_in_byte),
        .o_state           (n_state),
        .o_burst           (n_burst)
    );

    assign remaining   = r_burst.cnt - r_head;
    assign o_res_valid = remaining != 3'd0;
    assign o_in_stall  = (remaining > 3'd1) || (remaining == 3'd1 && i_res_stall);
    assign in_xfer     = i_in_valid && !o_in_stall;
    assign res_xfer    = o_res_valid && !i_res_stall;
    assign at_tail     = remaining == 3'd1;

    assign o_out_byte     = r_burst.bytes[r_head[1:0]];
    assign o_out_valid    = r_burst.data;
    assign o_last         = r_burst.last && at_tail;
    assign o_status       = r_burst.status;
    assign o_total_length = (r_burst.last && at_tail) ? r_burst.total : 8'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_r_length        <= ecdsa_der_pkg::RESET_R_LENGTH;
            r_s_length        <= ecdsa_der_pkg::RESET_S_LENGTH;
            r_buffer_capacity <= ecdsa_der_pkg::RESET_BUFFER_CAPACITY;
        end else if (i_cfg_we) begin
            case (ecdsa_der_pkg::t_cfg_index'(i_cfg_index))
                ecdsa_der_pkg::CFG_R_LENGTH:        r_r_length        <= i_cfg_data[6:0];
                ecdsa_der_pkg::CFG_S_LENGTH:        r_s_length        <= i_cfg_data[6:0];
                ecdsa_der_pkg::CFG_BUFFER_CAPACITY: r_buffer_capacity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.s_part     <= 1'b0;
            r_state.byte_count <= 7'd0;
            r_state.stripping  <= 1'b1;
            r_state.emitted    <= 8'd0;
            r_burst            <= '0;
            r_head             <= 3'd0;
        end else if (in_xfer) begin
            r_state <= n_state;
            r_burst <= n_burst;
            r_head  <= 3'd0;
        end else if (res_xfer) begin
            r_head <= r_head + 3'd1;
        end
    end

    a_head_in_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_head <= r_burst.cnt && r_burst.cnt <= 3'(ecdsa_der_pkg::BURST_MAX))
        else $error("burst head beyond burst count");

    a_error_is_status_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid && o_status != ecdsa_der_pkg::ST_OK |-> !o_out_valid && o_last)
        else $error("error result carries data or is not final");

    a_final_clears_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer && n_burst.last |=> !r_state.s_part && r_state.byte_count == 7'd0
                                    && r_state.emitted == 8'd0)
        else $error("state not cleared after final byte");

endmodule
